[rtl/core/ttce_pkg.sv]
package ttce_pkg;

  localparam int CP_W = 21;
  localparam int CFG_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  localparam int DEF_MAX_COLUMNS = 256;
  localparam int DEF_MAX_ROWS = 128;
  localparam int TAB_LIMIT = 8;

  localparam logic [8:0] RST_COLUMNS = 9'd80;
  localparam logic [7:0] RST_ROWS = 8'd25;
  localparam logic [3:0] RST_TAB_WIDTH = 4'd8;
  localparam logic [3:0] RST_VTAB_LINES = 4'd6;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VTAB_LINES = 2'd3;

  localparam logic [CP_W-1:0] CP_BACKSPACE = 21'h08;
  localparam logic [CP_W-1:0] CP_HTAB = 21'h09;
  localparam logic [CP_W-1:0] CP_LINE_FEED = 21'h0A;
  localparam logic [CP_W-1:0] CP_VTAB = 21'h0B;
  localparam logic [CP_W-1:0] CP_CARRIAGE_RET = 21'h0D;
  localparam logic [CP_W-1:0] CP_SPACE = 21'h20;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_DRAW    = 2'd0,
    CMD_SCROLL  = 2'd1,
    CMD_REFRESH = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    OP_REFRESH   = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_VTAB      = 3'd2,
    OP_TAB       = 3'd3,
    OP_BACKSPACE = 3'd4,
    OP_PUT       = 3'd5
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CP_W-1:0] cp;
  } op_t;

  typedef struct packed {
    cmd_e            cmd;
    logic [7:0]      x;
    logic [6:0]      y;
    logic [CP_W-1:0] cp;
    logic [7:0]      lines;
    logic            last;
  } res_t;

  function automatic op_t classify(input logic [CP_W-1:0] cp);
    op_t o;
    o.cp = cp;
    if (cp == CP_LINE_FEED || cp == CP_CARRIAGE_RET) begin
      o.op = OP_NEWLINE;
    end else if (cp == CP_VTAB) begin
      o.op = OP_VTAB;
    end else if (cp == CP_HTAB) begin
      o.op = OP_TAB;
    end else if (cp == CP_BACKSPACE) begin
      o.op = OP_BACKSPACE;
    end else begin
      o.op = OP_PUT;
    end
    return o;
  endfunction

endpackage

[rtl/core/ttce_utf8_front.sv]
module ttce_utf8_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic [ttce_pkg::IN_TDATA_W-1:0]    byte_i,
  input  logic                               full_i,
  output logic                               push_o,
  output ttce_pkg::op_t                      op_o
);

  logic [ttce_pkg::CP_W-1:0] partial_q, partial_d;
  logic [2:0]                need_q, need_d;
  logic [2:0]                seen_q, seen_d;
  logic [ttce_pkg::CP_W-1:0] acc;
  logic                      accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign acc        = ttce_pkg::CP_W'({partial_q, byte_i[5:0]});

  always_comb begin
    partial_d = partial_q;
    need_d    = need_q;
    seen_d    = seen_q;
    push_o    = 1'b0;
    op_o      = ttce_pkg::classify(ttce_pkg::CP_W'(byte_i));
    if (accept) begin
      if (kind_i) begin
        partial_d = '0;
        need_d    = '0;
        seen_d    = '0;
        push_o    = 1'b1;
        op_o.op   = ttce_pkg::OP_REFRESH;
        op_o.cp   = '0;
      end else if (seen_q < need_q) begin
        if (seen_q + 3'd1 >= need_q) begin
          partial_d = '0;
          need_d    = '0;
          seen_d    = '0;
          push_o    = 1'b1;
          op_o      = ttce_pkg::classify(acc);
        end else begin
          partial_d = acc;
          seen_d    = seen_q + 3'd1;
        end
      end else begin
        partial_d = '0;
        need_d    = '0;
        seen_d    = '0;
        if (byte_i[7:5] == 3'b110) begin
          partial_d = ttce_pkg::CP_W'(byte_i[4:0]);
          need_d    = 3'd2;
          seen_d    = 3'd1;
        end else if (byte_i[7:4] == 4'b1110) begin
          partial_d = ttce_pkg::CP_W'(byte_i[3:0]);
          need_d    = 3'd3;
          seen_d    = 3'd1;
        end else if (byte_i[7:3] == 5'b11110) begin
          partial_d = ttce_pkg::CP_W'(byte_i[2:0]);
          need_d    = 3'd4;
          seen_d    = 3'd1;
        end else begin
          push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      need_q    <= '0;
      seen_q    <= '0;
    end else begin
      partial_q <= partial_d;
      need_q    <= need_d;
      seen_q    <= seen_d;
    end
  end

endmodule

[rtl/core/ttce_op_fifo.sv]
module ttce_op_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ttce_pkg::op_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ttce_pkg::op_t data_o
);

  ttce_pkg::op_t                   mem_q [ttce_pkg::FIFO_DEPTH];
  logic [ttce_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [ttce_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == ttce_pkg::FIFO_CNT_W'(ttce_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/ttce_cursor_back.sv]
module ttce_cursor_back #(
  parameter int MAX_COLUMNS = ttce_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ttce_pkg::DEF_MAX_ROWS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [8:0]    columns_i,
  input  logic [7:0]    rows_i,
  input  logic [3:0]    tab_width_i,
  input  logic [3:0]    vtab_lines_i,
  input  logic          empty_i,
  input  ttce_pkg::op_t op_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ttce_pkg::res_t res_o
);

  localparam int CL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RL_W  = $clog2(MAX_ROWS + 1);
  localparam int SUM_W = ((RL_W > ROW_W) ? RL_W : ROW_W) + 5;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state_q, state_d;
  logic [CL_W-1:0]           col_q, col_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [3:0]                cnt_q, cnt_d;
  ttce_pkg::op_e             op_q, op_d;
  logic [ttce_pkg::CP_W-1:0] cp_q, cp_d;
  logic                      out_valid_q, out_valid_d;
  ttce_pkg::res_t            res_q, res_d;

  logic [CL_W-1:0]  clim;
  logic [RL_W-1:0]  rlim;
  logic [SUM_W-1:0] rlim_w, row_w, sum, n_lines;
  logic [3:0]       times, tab_n;
  logic             out_free, emit;
  ttce_pkg::res_t   res;

  always_comb begin
    if (columns_i == '0) begin
      clim = CL_W'(1);
    end else if (32'(columns_i) > MAX_COLUMNS) begin
      clim = CL_W'(MAX_COLUMNS);
    end else begin
      clim = CL_W'(columns_i);
    end
    if (rows_i == '0) begin
      rlim = RL_W'(1);
    end else if (32'(rows_i) > MAX_ROWS) begin
      rlim = RL_W'(MAX_ROWS);
    end else begin
      rlim = RL_W'(rows_i);
    end
  end

  assign rlim_w   = SUM_W'(rlim);
  assign row_w    = SUM_W'(row_q);
  assign times    = (op_q == ttce_pkg::OP_VTAB) ? vtab_lines_i : 4'd1;
  assign sum      = row_w + SUM_W'(times);
  assign n_lines  = (sum - rlim_w + SUM_W'(1) > rlim_w) ? rlim_w : sum - rlim_w + SUM_W'(1);
  assign tab_n    = (tab_width_i > 4'(ttce_pkg::TAB_LIMIT)) ? 4'(ttce_pkg::TAB_LIMIT)
                                                            : tab_width_i;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    cp_d    = cp_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    res     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          op_d    = op_i.op;
          cp_d    = (op_i.op == ttce_pkg::OP_TAB || op_i.op == ttce_pkg::OP_BACKSPACE)
                    ? ttce_pkg::CP_SPACE : op_i.cp;
          cnt_d   = (op_i.op == ttce_pkg::OP_TAB) ? tab_n : 4'd1;
          state_d = ST_RUN;
          if (op_i.op != ttce_pkg::OP_REFRESH) begin
            if (col_q > clim) begin
              col_d = clim;
            end
            if (row_w > rlim_w - SUM_W'(1)) begin
              row_d = ROW_W'(rlim_w - SUM_W'(1));
            end
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          unique case (op_q)
            ttce_pkg::OP_REFRESH: begin
              emit     = 1'b1;
              res.cmd  = ttce_pkg::CMD_REFRESH;
              res.last = 1'b1;
              state_d  = ST_IDLE;
            end
            ttce_pkg::OP_NEWLINE, ttce_pkg::OP_VTAB: begin
              col_d = '0;
              if (sum >= rlim_w) begin
                emit      = 1'b1;
                res.cmd   = ttce_pkg::CMD_SCROLL;
                res.lines = 8'(n_lines);
                res.last  = 1'b1;
                row_d     = ROW_W'(rlim_w - SUM_W'(1));
              end else begin
                row_d = ROW_W'(sum);
              end
              state_d = ST_IDLE;
            end
            ttce_pkg::OP_BACKSPACE: begin
              if (col_q != '0) begin
                emit     = 1'b1;
                res.cmd  = ttce_pkg::CMD_DRAW;
                res.x    = 8'(col_q - 1'b1);
                res.y    = 7'(row_q);
                res.cp   = cp_q;
                res.last = 1'b1;
                col_d    = col_q - 1'b1;
              end else if (row_q != '0) begin
                emit     = 1'b1;
                res.cmd  = ttce_pkg::CMD_DRAW;
                res.x    = 8'(clim - 1'b1);
                res.y    = 7'(row_q - 1'b1);
                res.cp   = cp_q;
                res.last = 1'b1;
                col_d    = clim - 1'b1;
                row_d    = row_q - 1'b1;
              end
              state_d = ST_IDLE;
            end
            ttce_pkg::OP_TAB, ttce_pkg::OP_PUT: begin
              if (cnt_q == '0) begin
                state_d = ST_IDLE;
              end else if (col_q >= clim) begin
                col_d = '0;
                if (row_w + SUM_W'(1) >= rlim_w) begin
                  emit      = 1'b1;
                  res.cmd   = ttce_pkg::CMD_SCROLL;
                  res.lines = 8'd1;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else begin
                emit     = 1'b1;
                res.cmd  = ttce_pkg::CMD_DRAW;
                res.x    = 8'(col_q);
                res.y    = 7'(row_q);
                res.cp   = cp_q;
                res.last = (cnt_q == 4'd1);
                col_d    = col_q + 1'b1;
                cnt_d    = cnt_q - 4'd1;
                if (cnt_q == 4'd1) begin
                  state_d = ST_IDLE;
                end
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (emit) begin
      out_valid_d = 1'b1;
      res_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    cp_q  <= cp_d;
    res_q <= res_d;
  end

endmodule

[rtl/core/text_terminal_cursor_engine.sv]
// Channel   Direction  Ports         Words carried
// s_axis    in         tdata, tuser  tdata = text_byte; tuser = kind
// m_axis    out        tdata, tuser, tdata = cell_x, cell_y, code_point, scroll_lines;
//                      tlast         tuser = command; tlast = last
// cfg       in         we, idx, data register write, no read-back
//
// A text byte or end word is decoded as it is accepted and enters the queue at that edge.
// The cursor sequencer then fetches the operation in its idle state and, in its run state,
// makes one result word or line wrap at a time while the output register is free or taken.
// Each space of a tab may first need a line wrap.
// Reset is asynchronous; cursor, decoder state and registers come up at once.
// A two-word queue lets a result that is not taken hold the sequencer apart from the input.
module text_terminal_cursor_engine #(
  parameter int MAX_COLUMNS = ttce_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ttce_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ttce_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // text_byte
  input  logic                                s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cell_x, cell_y, code_point, scroll_lines, zero pad
  output logic [ttce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic [ttce_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // command
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic [ttce_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ttce_pkg::CFG_W-1:0]          cfg_wdata_i
);

  logic [8:0]     columns_q;
  logic [7:0]     rows_q;
  logic [3:0]     tab_width_q;
  logic [3:0]     vtab_lines_q;
  logic           push, full, pop, empty;
  ttce_pkg::op_t  push_op, head_op;
  ttce_pkg::res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q    <= ttce_pkg::RST_COLUMNS;
      rows_q       <= ttce_pkg::RST_ROWS;
      tab_width_q  <= ttce_pkg::RST_TAB_WIDTH;
      vtab_lines_q <= ttce_pkg::RST_VTAB_LINES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttce_pkg::REG_COLUMNS:    columns_q    <= cfg_wdata_i[8:0];
        ttce_pkg::REG_ROWS:       rows_q       <= cfg_wdata_i[7:0];
        ttce_pkg::REG_TAB_WIDTH:  tab_width_q  <= cfg_wdata_i[3:0];
        ttce_pkg::REG_VTAB_LINES: vtab_lines_q <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  ttce_utf8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (s_axis_tuser),
    .byte_i     (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .op_o       (push_op)
  );

  ttce_op_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_op)
  );

  ttce_cursor_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .columns_i    (columns_q),
    .rows_i       (rows_q),
    .tab_width_i  (tab_width_q),
    .vtab_lines_i (vtab_lines_q),
    .empty_i      (empty),
    .op_i         (head_op),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {4'b0000, res.lines, res.cp, res.y, res.x};
  assign m_axis_tuser = res.cmd;
  assign m_axis_tlast = res.last;

endmodule

[verif/text_terminal_cursor_engine_test.sv]
`timescale 1ns / 1ps

module text_terminal_cursor_engine_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_PERCENT = 12;
  localparam int PHASE_WORDS = 18;

  class cursor_scoreboard;
    ttce_pkg::res_t pending[$];
    ttce_pkg::res_t step_cmds[$];
    int unsigned columns;
    int unsigned rows;
    int unsigned tab_width;
    int unsigned vtab_lines;
    int unsigned col;
    int unsigned row;
    int unsigned partial;
    int unsigned needed;
    int unsigned seen;
    int errors;

    function new();
      columns = ttce_pkg::RST_COLUMNS;
      rows = ttce_pkg::RST_ROWS;
      tab_width = ttce_pkg::RST_TAB_WIDTH;
      vtab_lines = ttce_pkg::RST_VTAB_LINES;
      col = 0;
      row = 0;
      partial = 0;
      needed = 0;
      seen = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [ttce_pkg::CFG_IDX_W-1:0] idx,
                            logic [ttce_pkg::CFG_W-1:0] value);
      case (idx)
        ttce_pkg::REG_COLUMNS: columns = value;
        ttce_pkg::REG_ROWS: rows = value[7:0];
        ttce_pkg::REG_TAB_WIDTH: tab_width = value[3:0];
        ttce_pkg::REG_VTAB_LINES: vtab_lines = value[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned screen_cols();
      if (columns < 1) return 1;
      if (columns > ttce_pkg::DEF_MAX_COLUMNS) return ttce_pkg::DEF_MAX_COLUMNS;
      return columns;
    endfunction

    function int unsigned screen_rows();
      if (rows < 1) return 1;
      if (rows > ttce_pkg::DEF_MAX_ROWS) return ttce_pkg::DEF_MAX_ROWS;
      return rows;
    endfunction

    function void push_cmd(ttce_pkg::cmd_e cmd, int unsigned x, int unsigned y,
                           int unsigned cp, int unsigned lines);
      ttce_pkg::res_t r;
      if (step_cmds.size() >= 16) return;
      r.cmd = cmd;
      r.x = x[7:0];
      r.y = y[6:0];
      r.cp = cp[ttce_pkg::CP_W-1:0];
      r.lines = lines[7:0];
      r.last = 1'b0;
      step_cmds.push_back(r);
    endfunction

    function void advance_lines(int unsigned times);
      int unsigned r;
      int unsigned n;
      r = screen_rows();
      col = 0;
      if (row + times >= r) begin
        n = row + times - r + 1;
        if (n > r) n = r;
        push_cmd(ttce_pkg::CMD_SCROLL, 0, 0, 0, n);
        row = r - 1;
      end else begin
        row = row + times;
      end
    endfunction

    function void place_cell(int unsigned cp);
      if (col >= screen_cols()) advance_lines(1);
      push_cmd(ttce_pkg::CMD_DRAW, col, row, cp, 0);
      col++;
    endfunction

    function void apply_point(int unsigned cp);
      int unsigned c;
      int unsigned r;
      int unsigned n;
      c = screen_cols();
      r = screen_rows();
      if (col > c) col = c;
      if (row > r - 1) row = r - 1;
      if (cp == ttce_pkg::CP_LINE_FEED || cp == ttce_pkg::CP_CARRIAGE_RET) begin
        advance_lines(1);
      end else if (cp == ttce_pkg::CP_VTAB) begin
        advance_lines(vtab_lines);
      end else if (cp == ttce_pkg::CP_HTAB) begin
        n = (tab_width > ttce_pkg::TAB_LIMIT) ? ttce_pkg::TAB_LIMIT : tab_width;
        repeat (n) place_cell(ttce_pkg::CP_SPACE);
      end else if (cp == ttce_pkg::CP_BACKSPACE) begin
        if (col > 0) begin
          col--;
          place_cell(ttce_pkg::CP_SPACE);
          col--;
        end else if (row > 0) begin
          row--;
          col = c - 1;
          place_cell(ttce_pkg::CP_SPACE);
          col = c - 1;
        end
      end else begin
        place_cell(cp);
      end
    endfunction

    function void take_word(bit kind, logic [7:0] b);
      int unsigned cp;
      step_cmds.delete();
      if (kind) begin
        partial = 0;
        needed = 0;
        seen = 0;
        push_cmd(ttce_pkg::CMD_REFRESH, 0, 0, 0, 0);
      end else if (seen < needed) begin
        partial = ((partial << 6) | (b & 8'h3F)) & 32'h1F_FFFF;
        seen++;
        if (seen >= needed) begin
          cp = partial;
          partial = 0;
          needed = 0;
          seen = 0;
          apply_point(cp);
        end
      end else begin
        partial = 0;
        needed = 0;
        seen = 0;
        if ((b & 8'hE0) == 8'hC0) begin
          partial = b & 8'h1F;
          needed = 2;
          seen = 1;
        end else if ((b & 8'hF0) == 8'hE0) begin
          partial = b & 8'h0F;
          needed = 3;
          seen = 1;
        end else if ((b & 8'hF8) == 8'hF0) begin
          partial = b & 8'h07;
          needed = 4;
          seen = 1;
        end else begin
          apply_point(b);
        end
      end
      if (step_cmds.size() > 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
      foreach (step_cmds[i]) pending.push_back(step_cmds[i]);
    endfunction

    function void check_word(logic [1:0] cmd, logic [7:0] x, logic [6:0] y,
                             logic [ttce_pkg::CP_W-1:0] cp, logic [7:0] lines,
                             logic is_last);
      ttce_pkg::res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: cmd=%0d x=%0d y=%0d cp=%h lines=%0d last=%b",
                   cmd, x, y, cp, lines, is_last);
        return;
      end
      want = pending.pop_front();
      if (cmd !== want.cmd || x !== want.x || y !== want.y || cp !== want.cp ||
          lines !== want.lines || is_last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected cmd=%0d x=%0d y=%0d cp=%h lines=%0d last=%b",
                   want.cmd, want.x, want.y, want.cp, want.lines, want.last);
          $display("          got      cmd=%0d x=%0d y=%0d cp=%h lines=%0d last=%b",
                   cmd, x, y, cp, lines, is_last);
        end
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [ttce_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [ttce_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [ttce_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
  logic                             m_axis_tlast;
  logic                             cfg_we_i = 1'b0;
  logic [ttce_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [ttce_pkg::CFG_W-1:0]       cfg_wdata_i = '0;

  cursor_scoreboard board = new();
  int cycle_count = 0;
  int words_sent = 0;
  int hold_off_left = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  text_terminal_cursor_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // The receiver stalls at random, and for one long stretch on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_left--;
      end else begin
        m_axis_tready <= !(out_idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[14:8],
                       m_axis_tdata[35:15], m_axis_tdata[43:36], m_axis_tlast);
  end

  task automatic send_word(input bit kind, input logic [7:0] b);
    while (in_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_word(kind, b);
    words_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [ttce_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ttce_pkg::CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    board.write_reg(idx, value);
  endtask

  task automatic send_random_item();
    int pick;
    int len;
    logic [7:0] r;
    logic [7:0] ctrl[5];
    ctrl = '{8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0D};
    pick = $urandom_range(99);
    r = 8'($urandom_range(255));
    if (pick < 8) begin
      send_word(1'b1, r);
    end else if (pick < 24) begin
      send_word(1'b0, ctrl[$urandom_range(4)]);
    end else if (pick < 55) begin
      send_word(1'b0, 8'($urandom_range(8'h7E, 8'h20)));
    end else if (pick < 82) begin
      len = $urandom_range(4, 2);
      case (len)
        2: send_word(1'b0, 8'hC0 | (r & 8'h1F));
        3: send_word(1'b0, 8'hE0 | (r & 8'h0F));
        default: send_word(1'b0, 8'hF0 | (r & 8'h07));
      endcase
      repeat (len - 1) send_word(1'b0, 8'h80 | 8'($urandom_range(63)));
    end else begin
      send_word(1'b0, r);
    end
  endtask

  task automatic run_phase(input int unsigned cols, input int unsigned nrows,
                           input int unsigned tabs, input int unsigned vtabs,
                           input int count, input bit squeeze, input bit steady);
    int stop_at;
    settle();
    write_register(ttce_pkg::REG_COLUMNS, ttce_pkg::CFG_W'(cols));
    write_register(ttce_pkg::REG_ROWS, ttce_pkg::CFG_W'(nrows));
    write_register(ttce_pkg::REG_TAB_WIDTH, ttce_pkg::CFG_W'(tabs));
    write_register(ttce_pkg::REG_VTAB_LINES, ttce_pkg::CFG_W'(vtabs));
    cfg_we_i <= 1'b0;
    in_idle_on = !steady;
    out_idle_on = !steady;
    if (squeeze) hold_off_left = HOLD_OFF_CYCLES;
    stop_at = words_sent + count;
    while (words_sent < stop_at) send_random_item();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    logic [8:0] directed[$];
    directed = '{9'h008, 9'h041, 9'h000, 9'h07F, 9'h0FF, 9'h080, 9'h0C3, 9'h0A9,
                 9'h0E2, 9'h082, 9'h0AC, 9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0C0,
                 9'h08A, 9'h009, 9'h008, 9'h00A, 9'h008, 9'h00D, 9'h00B, 9'h0E2,
                 9'h100, 9'h100};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_word(directed[i][8], directed[i][7:0]);

    run_phase(1, 1, 1, 1, PHASE_WORDS, 1'b0, 1'b0);
    run_phase(256, 128, 8, 15, PHASE_WORDS, 1'b1, 1'b0);
    run_phase(0, 0, 0, 0, PHASE_WORDS, 1'b0, 1'b0);
    run_phase(511, 255, 15, 15, PHASE_WORDS, 1'b0, 1'b0);
    run_phase(7, 4, 3, 2, PHASE_WORDS, 1'b0, 1'b1);
    run_phase($urandom_range(20, 1), $urandom_range(10, 1), $urandom_range(15),
              $urandom_range(15), PHASE_WORDS, 1'b0, 1'b0);

    settle();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
